@@ src/bfm_pkg.sv @@
// Package for the bloom filter map core: shared types, codes and constants.
// Depends on nothing; used by every module of the block.
`default_nettype none
package bfm_pkg;

    localparam int FILTER_BITS_DEF   = 256;
    localparam int MAX_KEY_BYTES_DEF = 16;
    localparam logic [31:0] HASH_INIT = 32'hdeadbeef;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [1:0] STATUS_INVALID  = 2'd2;

    localparam logic [1:0] CFG_KEY_LENGTH = 2'd0;
    localparam logic [1:0] CFG_HASH_COUNT = 2'd1;
    localparam logic [1:0] CFG_SEED       = 2'd2;

    typedef struct packed {
        logic [4:0]  key_length;
        logic [3:0]  hash_count;
        logic [31:0] seed;
    } bfm_cfg_t;

    typedef struct packed {
        logic             insert;
        logic             invalid;
        logic [3:0][31:0] key;
    } bfm_item_t;

    typedef struct packed {
        logic      valid;
        bfm_item_t item;
    } bfm_q_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage
`default_nettype wire

@@ src/bfm_front.sv @@
// Front part: accepts input transactions, classifies them and queues them.
// Depends on bfm_pkg.
`default_nettype none
module bfm_front import bfm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [31:0] key_word0,
    input  wire logic [31:0] key_word1,
    input  wire logic [31:0] key_word2,
    input  wire logic [31:0] key_word3,
    input  wire logic        flag_set,
    output bfm_q_t           q,
    input  wire logic        pop
);

    bfm_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;
    bfm_item_t  new_item;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != 2'd0);

    always_comb
    begin
        new_item.insert  = kind;
        new_item.invalid = kind && flag_set;
        new_item.key     = {key_word3, key_word2, key_word1, key_word0};
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign q.valid = (count_reg != 2'd0);
    assign q.item  = entry_reg[rd_ptr_reg];

endmodule
`default_nettype wire

@@ src/bfm_back.sv @@
// Back part: runs the Jenkins hash sequencer, probes and sets the bit store,
// and holds the result register. Depends on bfm_pkg.
`default_nettype none
module bfm_back import bfm_pkg::*;
#(
    parameter int FILTER_BITS   = FILTER_BITS_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bfm_cfg_t cfg,
    input  wire bfm_q_t   q,
    output logic          pop,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [1:0]    status
);

    localparam int POS_W = $clog2(FILTER_BITS);
    localparam logic [4:0] MAX_LEN = 5'(MAX_KEY_BYTES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_MIX   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_PROBE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [2:0]             step_reg, step_next;
    logic [3:0]             idx_reg, idx_next;
    logic                   mixed_reg, mixed_next;
    logic [4:0]             len_reg, len_next;
    logic                   insert_reg, insert_next;
    logic [3:0][31:0]       key_reg, key_next;
    logic [31:0]            a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [1:0]             res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic [FILTER_BITS-1:0] bits_reg, bits_next;
    logic [31:0]            init_val;
    logic [POS_W-1:0]       pos;

    function automatic logic [31:0] byte_mask(input logic [4:0] len, input logic [4:0] start);
        logic [4:0] n;
        n = (len > start) ? (len - start) : 5'd0;
        if (n >= 5'd4)
            return 32'hffffffff;
        return (32'd1 << {n[1:0], 3'b000}) - 32'd1;
    endfunction

    assign init_val = HASH_INIT + {27'd0, len_reg} + cfg.seed + {28'd0, idx_reg};
    assign pos      = c_reg[POS_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        mixed_next      = mixed_reg;
        len_next        = len_reg;
        insert_next     = insert_reg;
        key_next        = key_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        res_next        = res_reg;
        bits_next       = bits_reg;
        pop             = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q.valid)
                begin
                    pop         = 1'b1;
                    insert_next = q.item.insert;
                    key_next    = q.item.key;
                    len_next    = (cfg.key_length > MAX_LEN) ? MAX_LEN : cfg.key_length;
                    idx_next    = 4'd0;
                    res_next    = STATUS_OK;
                    if (q.item.invalid)
                    begin
                        res_next   = STATUS_INVALID;
                        state_next = ST_DONE;
                    end
                    else if (cfg.hash_count == 4'd0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                a_next     = init_val;
                b_next     = init_val;
                c_next     = init_val;
                mixed_next = 1'b0;
                step_next  = 3'd0;
                state_next = (len_reg == 5'd0) ? ST_PROBE : ST_ACC;
            end
            ST_ACC:
            begin
                step_next = 3'd0;
                if (!mixed_reg)
                begin
                    a_next = a_reg + (key_reg[0] & byte_mask(len_reg, 5'd0));
                    b_next = b_reg + (key_reg[1] & byte_mask(len_reg, 5'd4));
                    c_next = c_reg + (key_reg[2] & byte_mask(len_reg, 5'd8));
                    state_next = (len_reg > 5'd12) ? ST_MIX : ST_FIN;
                end
                else
                begin
                    a_next     = a_reg + (key_reg[3] & byte_mask(len_reg, 5'd12));
                    state_next = ST_FIN;
                end
            end
            ST_MIX:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        a_next = (a_reg - c_reg) ^ rotl(c_reg, 4);
                        c_next = c_reg + b_reg;
                    end
                    3'd1:
                    begin
                        b_next = (b_reg - a_reg) ^ rotl(a_reg, 6);
                        a_next = a_reg + c_reg;
                    end
                    3'd2:
                    begin
                        c_next = (c_reg - b_reg) ^ rotl(b_reg, 8);
                        b_next = b_reg + a_reg;
                    end
                    3'd3:
                    begin
                        a_next = (a_reg - c_reg) ^ rotl(c_reg, 16);
                        c_next = c_reg + b_reg;
                    end
                    3'd4:
                    begin
                        b_next = (b_reg - a_reg) ^ rotl(a_reg, 19);
                        a_next = a_reg + c_reg;
                    end
                    default:
                    begin
                        c_next     = (c_reg - b_reg) ^ rotl(b_reg, 4);
                        b_next     = b_reg + a_reg;
                        mixed_next = 1'b1;
                        state_next = ST_ACC;
                    end
                endcase
            end
            ST_FIN:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: c_next = (c_reg ^ b_reg) - rotl(b_reg, 14);
                    3'd1: a_next = (a_reg ^ c_reg) - rotl(c_reg, 11);
                    3'd2: b_next = (b_reg ^ a_reg) - rotl(a_reg, 25);
                    3'd3: c_next = (c_reg ^ b_reg) - rotl(b_reg, 16);
                    3'd4: a_next = (a_reg ^ c_reg) - rotl(c_reg, 4);
                    3'd5: b_next = (b_reg ^ a_reg) - rotl(a_reg, 14);
                    default:
                    begin
                        c_next     = (c_reg ^ b_reg) - rotl(b_reg, 24);
                        state_next = ST_PROBE;
                    end
                endcase
            end
            ST_PROBE:
            begin
                if (insert_reg)
                begin
                    bits_next[pos] = 1'b1;
                end
                if (!insert_reg && !bits_reg[pos])
                begin
                    res_next   = STATUS_NOTFOUND;
                    state_next = ST_DONE;
                end
                else if (idx_reg == cfg.hash_count - 4'd1)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = ST_INIT;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 3'd0;
            idx_reg       <= 4'd0;
            mixed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            bits_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            mixed_reg     <= mixed_next;
            out_valid_reg <= out_valid_next;
            bits_reg      <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        insert_reg     <= insert_next;
        key_reg        <= key_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;

endmodule
`default_nettype wire

@@ src/bloom_filter_map_core.sv @@
// An invalid insert or a zero hash count goes straight to the result. Otherwise each hash
// index runs the init, accumulate, final and probe steps (len 13..16 adds a mix and a second
// accumulate; len 0 goes from init to probe), one hash step per cycle. The back part takes
// a new transaction only after the last result is written, and that waits while the result
// is stalled; a queue of two transactions sits in front. Asynchronous active-low reset
// clears the bit store, queue and result valid flag and sets the configuration to defaults.
`default_nettype none
module bloom_filter_map_core import bfm_pkg::*;
#(
    parameter int FILTER_BITS   = FILTER_BITS_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [31:0] key_word0,
    input  wire logic [31:0] key_word1,
    input  wire logic [31:0] key_word2,
    input  wire logic [31:0] key_word3,
    input  wire logic        flag_set,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    bfm_cfg_t cfg_reg;
    bfm_q_t   q;
    logic     pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_length <= 5'd4;
            cfg_reg.hash_count <= 4'd3;
            cfg_reg.seed       <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LENGTH: cfg_reg.key_length <= cfg_data[4:0];
                CFG_HASH_COUNT: cfg_reg.hash_count <= cfg_data[3:0];
                CFG_SEED:       cfg_reg.seed       <= cfg_data;
                default:        ;
            endcase
        end
    end

    bfm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .key_word0 (key_word0),
        .key_word1 (key_word1),
        .key_word2 (key_word2),
        .key_word3 (key_word3),
        .flag_set  (flag_set),
        .q         (q),
        .pop       (pop)
    );

    bfm_back #(
        .FILTER_BITS   (FILTER_BITS),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q         (q),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status)
    );

`ifndef NO_ASSERTIONS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_NOTFOUND
                       || status == STATUS_INVALID))
        else $error("result carries an undefined status code");

    a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> q.valid)
        else $error("accepted transaction missing from the queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q.valid)
        else $error("back part popped an empty queue");
`endif

endmodule
`default_nettype wire
